### hw/rtl/uftc_pkg.sv
// ----------------------------------------------------------------------------
// uftc_pkg
// Shared types and constants for the union-find tree check block.
// ----------------------------------------------------------------------------
package uftc_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int RANK_W     = 4;
    localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
    localparam logic [RANK_W-1:0] RANK_INIT = 4'd1;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_FIND_RD,
        ST_FIND_WT,
        ST_FIND_CHK,
        ST_COMP_RD,
        ST_COMP_WT,
        ST_COMP_CHK,
        ST_NEXT_END,
        ST_JOIN_RD,
        ST_JOIN_WT,
        ST_JOIN_WR,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_SCAN_CHK,
        ST_RESULT
    } state_t;

    // datapath commands
    typedef struct packed {
        logic clear_step;   // write reset values at sweep counter
        logic load_edge;    // latch operands, update bounds and edge flag
        logic sel_b;        // operate on second endpoint
        logic start_find;   // top = start node, mark it seen
        logic rd_top;       // read parent[top]
        logic adv_top;      // top = parent data
        logic start_comp;   // walk = start node
        logic rd_walk;      // read parent[walk]
        logic comp_step;    // parent[walk] = top, walk = old parent
        logic save_root;    // store root of current endpoint
        logic rd_ranks;     // read ranks of both roots
        logic do_join;      // write join result
        logic start_scan;   // scan index = lowest
        logic rd_scan;      // read parent and seen at scan index
        logic scan_step;    // count root, advance
        logic finish;       // compute result word
        logic start_clear;  // sweep counter = 0
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic top_is_root;
        logic walk_is_root;
        logic roots_equal;
        logic cycle;
        logic any_edge;
        logic scan_done;
    } stat_t;

endpackage

### hw/rtl/uftc_ctrl.sv
// ----------------------------------------------------------------------------
// uftc_ctrl
// Sequencer for edge processing, end-of-case scan and store clearing.
// ----------------------------------------------------------------------------
module uftc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    output logic              res_load,
    input  logic              out_busy,
    input  uftc_pkg::stat_t   stat,
    output uftc_pkg::cmd_t    cmd
);

    uftc_pkg::state_t state_reg, state_next;
    logic second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= uftc_pkg::ST_CLEAR;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            uftc_pkg::ST_CLEAR:
                if (stat.clear_done) state_next = uftc_pkg::ST_IDLE;
            uftc_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (in_cmd)
                    begin
                        if (!stat.any_edge || stat.cycle)
                            state_next = uftc_pkg::ST_RESULT;
                        else
                            state_next = uftc_pkg::ST_SCAN_RD;
                    end
                    else if (!stat.cycle)
                    begin
                        state_next  = uftc_pkg::ST_FIND_RD;
                        second_next = 1'b0;
                    end
                end
            uftc_pkg::ST_EDGE:
                state_next = uftc_pkg::ST_FIND_RD;
            uftc_pkg::ST_FIND_RD:  state_next = uftc_pkg::ST_FIND_WT;
            uftc_pkg::ST_FIND_WT:  state_next = uftc_pkg::ST_FIND_CHK;
            uftc_pkg::ST_FIND_CHK:
                state_next = stat.top_is_root ? uftc_pkg::ST_COMP_RD
                                              : uftc_pkg::ST_FIND_RD;
            uftc_pkg::ST_COMP_RD:  state_next = uftc_pkg::ST_COMP_WT;
            uftc_pkg::ST_COMP_WT:  state_next = uftc_pkg::ST_COMP_CHK;
            uftc_pkg::ST_COMP_CHK:
                state_next = stat.walk_is_root ? uftc_pkg::ST_NEXT_END
                                               : uftc_pkg::ST_COMP_RD;
            uftc_pkg::ST_NEXT_END:
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = uftc_pkg::ST_EDGE;
                end
                else if (stat.roots_equal)
                    state_next = uftc_pkg::ST_IDLE;
                else
                    state_next = uftc_pkg::ST_JOIN_RD;
            uftc_pkg::ST_JOIN_RD:  state_next = uftc_pkg::ST_JOIN_WT;
            uftc_pkg::ST_JOIN_WT:  state_next = uftc_pkg::ST_JOIN_WR;
            uftc_pkg::ST_JOIN_WR:  state_next = uftc_pkg::ST_IDLE;
            uftc_pkg::ST_SCAN_RD:  state_next = uftc_pkg::ST_SCAN_WT;
            uftc_pkg::ST_SCAN_WT:  state_next = uftc_pkg::ST_SCAN_CHK;
            uftc_pkg::ST_SCAN_CHK:
                state_next = stat.scan_done ? uftc_pkg::ST_RESULT
                                            : uftc_pkg::ST_SCAN_RD;
            uftc_pkg::ST_RESULT:
                if (!out_busy) state_next = uftc_pkg::ST_CLEAR;
            default: state_next = uftc_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        res_load = 1'b0;
        cmd.sel_b = second_reg;
        unique case (state_reg)
            uftc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            uftc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !in_cmd && !stat.cycle)
                begin
                    cmd.load_edge  = 1'b1;
                    cmd.start_find = 1'b1;
                    cmd.sel_b      = 1'b0;
                end
                if (in_valid && in_cmd) cmd.start_scan = 1'b1;
            end
            uftc_pkg::ST_EDGE:     cmd.start_find = 1'b1;
            uftc_pkg::ST_FIND_RD:  cmd.rd_top = 1'b1;
            uftc_pkg::ST_FIND_CHK:
            begin
                if (stat.top_is_root) cmd.start_comp = 1'b1;
                else cmd.adv_top = 1'b1;
            end
            uftc_pkg::ST_COMP_RD:  cmd.rd_walk = 1'b1;
            uftc_pkg::ST_COMP_CHK:
            begin
                if (stat.walk_is_root) cmd.save_root = 1'b1;
                else cmd.comp_step = 1'b1;
            end
            uftc_pkg::ST_NEXT_END: ;
            uftc_pkg::ST_JOIN_RD:  cmd.rd_ranks = 1'b1;
            uftc_pkg::ST_JOIN_WR:  cmd.do_join = 1'b1;
            uftc_pkg::ST_SCAN_RD:  cmd.rd_scan = 1'b1;
            uftc_pkg::ST_SCAN_CHK: cmd.scan_step = 1'b1;
            uftc_pkg::ST_RESULT:
                if (!out_busy)
                begin
                    cmd.finish      = 1'b1;
                    cmd.start_clear = 1'b1;
                    res_load        = 1'b1;
                end
            default: ;
        endcase
    end

endmodule

### hw/rtl/uftc_dp.sv
// ----------------------------------------------------------------------------
// uftc_dp
// Parent, rank and seen stores with walk pointers, bounds and root counter.
// ----------------------------------------------------------------------------
module uftc_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  uftc_pkg::node_t      node_a,
    input  uftc_pkg::node_t      node_b,
    input  uftc_pkg::cmd_t       cmd,
    output uftc_pkg::stat_t      stat,
    output logic                 res_tree,
    output logic                 res_cycle
);

    localparam int NW = uftc_pkg::NODE_W;

    // parent words carry an extra top bit; rank and seen are kept separately
    logic [NW:0]                   pmem [uftc_pkg::NODE_COUNT];
    logic [uftc_pkg::RANK_W-1:0]   rmem [uftc_pkg::NODE_COUNT];

    uftc_pkg::node_t a_reg, b_reg, top_reg, walk_reg, ra_reg, rb_reg, scan_reg;
    uftc_pkg::node_t low_reg, high_reg;
    logic [NW:0]     clr_reg;
    logic [NW:0]     prd_reg;
    logic [uftc_pkg::RANK_W-1:0] rka_reg, rkb_reg;
    logic cycle_reg, any_reg;
    logic [1:0] roots_reg;  // saturating count: 0, 1, many

    uftc_pkg::node_t start_node, low_n, high_n;
    uftc_pkg::node_t prd_par;
    logic            prd_seen;
    logic [NW-1:0]   ra_idx;

    // load_edge shares the start_find cycle: start_node then comes from the
    // ports, so select them directly for the first endpoint
    assign start_node = cmd.load_edge ? node_a : (cmd.sel_b ? b_reg : a_reg);
    assign prd_par    = prd_reg[NW-1:0];
    assign prd_seen   = prd_reg[NW];
    assign ra_idx     = ra_reg;

    // memory port control
    logic          wr_en, rd_en;
    logic [NW-1:0] wr_addr, rd_addr;
    logic [NW:0]   wr_data;

    always_comb
    begin
        wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        rd_en = 1'b0; rd_addr = '0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1; wr_addr = clr_reg[NW-1:0]; wr_data = {1'b0, clr_reg[NW-1:0]};
        end
        else if (cmd.comp_step)
        begin
            wr_en = 1'b1; wr_addr = walk_reg; wr_data = {prd_seen, top_reg};
        end
        else if (cmd.do_join)
        begin
            wr_en = 1'b1;
            if (rka_reg < rkb_reg || rka_reg == rkb_reg)
            begin
                wr_addr = ra_reg; wr_data = {1'b1, rb_reg};
            end
            else
            begin
                wr_addr = rb_reg; wr_data = {1'b1, ra_reg};
            end
        end
        if (cmd.rd_top)  begin rd_en = 1'b1; rd_addr = top_reg;  end
        if (cmd.rd_walk) begin rd_en = 1'b1; rd_addr = walk_reg; end
        if (cmd.rd_scan) begin rd_en = 1'b1; rd_addr = scan_reg; end
        if (cmd.rd_ranks) begin rd_en = 1'b1; rd_addr = ra_idx; end
    end

    // mark the start node seen on the first find step of each endpoint
    logic seen_wr;
    uftc_pkg::node_t seen_addr;
    assign seen_wr   = cmd.start_find;
    assign seen_addr = start_node;

    // seen bits kept in their own memory so a mark needs no read
    logic smem [uftc_pkg::NODE_COUNT];
    logic srd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pmem[wr_addr] <= wr_data;
        if (rd_en)
            prd_reg <= pmem[rd_addr];
        if (cmd.clear_step)
            smem[clr_reg[NW-1:0]] <= 1'b0;
        else if (seen_wr)
            smem[seen_addr] <= 1'b1;
        if (cmd.rd_scan)
            srd_reg <= smem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            rmem[clr_reg[NW-1:0]] <= uftc_pkg::RANK_INIT;
        else if (cmd.do_join && rka_reg == rkb_reg && rkb_reg != uftc_pkg::RANK_MAX)
            rmem[rb_reg] <= rkb_reg + uftc_pkg::RANK_W'(1);
        if (cmd.rd_ranks)
        begin
            rka_reg <= rmem[ra_reg];
        end
        if (cmd.rd_ranks)
            rkb_reg <= rmem[rb_reg];
    end

    always_comb
    begin
        low_n  = low_reg;
        high_n = high_reg;
        if (node_a > high_n) high_n = node_a;
        if (node_b > high_n) high_n = node_b;
        if (node_a < low_n)  low_n  = node_a;
        if (node_b < low_n)  low_n  = node_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            cycle_reg <= 1'b0;
            any_reg   <= 1'b0;
            low_reg   <= '1;
            high_reg  <= '0;
            roots_reg <= '0;
            res_tree  <= 1'b0;
            res_cycle <= 1'b0;
        end
        else
        begin
            if (cmd.start_clear)
                clr_reg <= '0;
            else if (cmd.clear_step && !clr_reg[NW])
                clr_reg <= clr_reg + (NW+1)'(1);
            if (cmd.load_edge)
            begin
                any_reg  <= 1'b1;
                low_reg  <= low_n;
                high_reg <= high_n;
            end
            if (cmd.save_root && cmd.sel_b && (ra_reg == top_reg))
                cycle_reg <= 1'b1;
            if (cmd.start_scan)
                roots_reg <= '0;
            else if (cmd.scan_step && srd_reg && prd_par == scan_reg && roots_reg != 2'd2)
                roots_reg <= roots_reg + 2'd1;
            if (cmd.finish)
            begin
                res_tree  <= !any_reg || (!cycle_reg && roots_reg == 2'd1);
                res_cycle <= cycle_reg;
                cycle_reg <= 1'b0;
                any_reg   <= 1'b0;
                low_reg   <= '1;
                high_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_edge)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
        end
        if (cmd.start_find)
            top_reg <= start_node;
        else if (cmd.adv_top)
            top_reg <= prd_par;
        if (cmd.start_comp)
            walk_reg <= start_node;
        else if (cmd.comp_step)
            walk_reg <= prd_par;
        if (cmd.save_root)
        begin
            if (cmd.sel_b) rb_reg <= top_reg;
            else           ra_reg <= top_reg;
        end
        if (cmd.start_scan)
            scan_reg <= low_reg;
        else if (cmd.scan_step)
            scan_reg <= scan_reg + uftc_pkg::node_t'(1);
    end

    assign stat.clear_done   = clr_reg[NW];
    assign stat.top_is_root  = (prd_par == top_reg);
    assign stat.walk_is_root = (prd_par == walk_reg);
    assign stat.roots_equal  = (ra_reg == rb_reg);
    assign stat.cycle        = cycle_reg;
    assign stat.any_edge     = any_reg;
    assign stat.scan_done    = (scan_reg == high_reg) || (roots_reg == 2'd2);

endmodule

### hw/rtl/union_find_tree_check.sv
// ----------------------------------------------------------------------------
// union_find_tree_check
// Graph tree check over a disjoint-set forest with rank and path compression.
// ----------------------------------------------------------------------------
// An edge word is taken only in idle and then processed in full: each
// endpoint is walked to its root over its parent hops (ha and hb), each hop a
// read, wait and check step, and the path is compressed with the same steps,
// since parent-memory reads are registered. A merge of two distinct roots adds
// a rank read, wait and write step. An edge that arrives once the case holds a
// loop is taken and dropped. An end-of-case word after edges and no cycle
// scans from the lowest to the highest seen index, stopping early at a second
// root. Each end-of-case word waits while an earlier result word is still held,
// then goes valid via load_q_reg and out_valid_reg; the store is then cleared
// over every node (also after reset), during which no word is taken.
module union_find_tree_check
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [9:0]            node_a,
    input  logic [9:0]            node_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_tree,
    output logic                  had_cycle
);

    uftc_pkg::cmd_t  dcmd;
    uftc_pkg::stat_t stat;
    logic res_load, res_tree, res_cycle, ready_int;
    logic out_valid_reg, load_q_reg;

    uftc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (ready_int),
        .res_load (res_load),
        .out_busy (out_valid_reg && !out_ready),
        .stat     (stat),
        .cmd      (dcmd)
    );

    uftc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_a    (node_a),
        .node_b    (node_b),
        .cmd       (dcmd),
        .stat      (stat),
        .res_tree  (res_tree),
        .res_cycle (res_cycle)
    );

    assign in_ready = ready_int;

    // load_q_reg registers res_load; out_valid_reg is then set from load_q_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            load_q_reg    <= 1'b0;
        end
        else
        begin
            load_q_reg <= res_load;
            if (load_q_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_tree   = res_tree;
    assign had_cycle = res_cycle;

endmodule
